// ===== design/z85_pkg.sv =====
// shared types, constants and lookup functions for the z85 codec
package z85_pkg;

  // group sizes in items
  localparam logic [2:0] ENC_GROUP = 3'd4;
  localparam logic [2:0] DEC_GROUP = 3'd5;

  // reciprocal of 85 for a 32-bit dividend: q = (v * DIV85_MAGIC) >> DIV85_SHIFT
  localparam logic [31:0] DIV85_MAGIC = 32'hC0C0C0C1;
  localparam int          DIV85_SHIFT = 38;

  // number of base-85 digits in one encoded group
  localparam logic [2:0] ENC_DIGITS = 3'd5;

  // z85 alphabet, first character in the top byte
  localparam logic [85*8-1:0] ALPHA_STR =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

  // digit value of character codes 32 to 127, code 32 in the top byte
  localparam logic [96*8-1:0] DIGIT_TAB = {
    8'h00, 8'h44, 8'h00, 8'h54, 8'h53, 8'h52, 8'h48, 8'h00,
    8'h4B, 8'h4C, 8'h46, 8'h41, 8'h00, 8'h3F, 8'h3E, 8'h45,
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h08, 8'h09, 8'h40, 8'h00, 8'h49, 8'h42, 8'h4A, 8'h47,
    8'h51, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A,
    8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h32,
    8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3A,
    8'h3B, 8'h3C, 8'h3D, 8'h4D, 8'h00, 8'h4E, 8'h43, 8'h00,
    8'h00, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10,
    8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
    8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20,
    8'h21, 8'h22, 8'h23, 8'h4F, 8'h00, 8'h50, 8'h00, 8'h00
  };

  // one unit of work handed from the front to the back
  typedef struct packed {
    logic        enc;   // encode group (four bytes, giving five characters)
    logic [31:0] val;   // gathered group value
    logic        last;  // group closes the message
    logic        lerr;  // message ended mid-group
  } job_t;

  // base-85 digit to alphabet character
  function automatic logic [7:0] z85_char(input logic [6:0] d);
    logic [7:0] c;
    c = 8'd0;
    if (d < 7'd85) begin
      c = ALPHA_STR[8*(84 - int'(d)) +: 8];
    end
    return c;
  endfunction

  // character code to digit value, anything outside 32 to 127 gives 0
  function automatic logic [6:0] z85_digit(input logic [7:0] ch);
    logic [6:0] j;
    logic [7:0] e;
    j = ch[6:0] - 7'd32;
    e = 8'd0;
    if (!ch[7] && (ch[6:5] != 2'b00)) begin
      e = DIGIT_TAB[8*(95 - int'(j)) +: 8];
    end
    return e[6:0];
  endfunction

endpackage

// ===== design/z85_codec.sv =====
// top level of the streaming z85 encoder and decoder
//
//   channel   direction  handshake           word
//   in_       into       in_valid/in_stall   in_data_in, in_last_in
//   out_      out of     out_valid/out_stall out_data_out, out_group_last,
//                                            out_message_end, out_length_error
//   cfg_      into       cfg_valid/cfg_ready cfg_mode (0 encode, 1 decode)
//
// Input words are taken one per cycle while the two-entry job queue has room.
// An encode group runs through the back end as a string of divisions by 85 (one per cycle
// through a 32x32 reciprocal multiply), then a hand-off to the output buffer;
// decode groups leave as four words, one per cycle while the output is not stalled.
// Reset is synchronous, active low, and clears the mode to encode.
// A stalled output holds its word; the front keeps gathering until the queue fills.
module z85_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_mode,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_in,
  input  logic       in_last_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_out,
  output logic       out_group_last,
  output logic       out_message_end,
  output logic       out_length_error
);
  import z85_pkg::*;

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  z85_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_mode   (cfg_mode),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data_in (in_data_in),
    .in_last_in (in_last_in),
    .push       (push),
    .push_job   (push_job)
  );

  z85_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  z85_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_out     (out_data_out),
    .out_group_last   (out_group_last),
    .out_message_end  (out_message_end),
    .out_length_error (out_length_error)
  );

endmodule

// ===== design/z85_front.sv =====
// front end: mode register, group gathering and job issue
module z85_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  input  logic          cfg_mode,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [7:0]    in_data_in,
  input  logic          in_last_in,
  output logic          push,
  output z85_pkg::job_t push_job
);
  import z85_pkg::*;

  logic        mode_r;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_x85;
  logic [31:0] acc_step;
  logic [2:0]  cnt_inc;
  logic        grp_full;
  logic        accept;

  // next partial group value for either direction
  always_comb begin
    acc_x85  = (acc_r << 6) + (acc_r << 4) + (acc_r << 2) + acc_r;
    acc_step = mode_r ? (acc_x85 + {25'd0, z85_digit(in_data_in)})
                      : {acc_r[23:0], in_data_in};
    cnt_inc  = cnt_r + 3'd1;
    grp_full = mode_r ? (cnt_inc == DEC_GROUP) : (cnt_inc == ENC_GROUP);
    accept   = in_valid && !in_stall;
    push     = accept && (grp_full || in_last_in);
  end

  // job for a closed group or a short message
  always_comb begin
    push_job.enc  = !mode_r;
    push_job.val  = acc_step;
    push_job.last = in_last_in;
    push_job.lerr = !grp_full;
  end

  // gathering state, cleared when a group closes
  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (push) begin
      acc_nxt = 32'd0;
      cnt_nxt = 3'd0;
    end else if (accept) begin
      acc_nxt = acc_step;
      cnt_nxt = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      acc_r  <= 32'd0;
      cnt_r  <= 3'd0;
    end else if (cfg_valid) begin
      mode_r <= cfg_mode;
      acc_r  <= 32'd0;
      cnt_r  <= 3'd0;
    end else begin
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // a group never holds more items than its size
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < DEC_GROUP) else $error("group count out of range");

  a_clear_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    push && !cfg_valid |=> (cnt_r == 3'd0) && (acc_r == 32'd0))
    else $error("group state not cleared after issue");

  a_enc_count: assert property (@(posedge clk) disable iff (!rst_n)
    !mode_r |-> cnt_r < ENC_GROUP) else $error("encode group overfilled");

endmodule

// ===== design/z85_queue.sv =====
// two-entry job queue between front and back
module z85_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  z85_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output z85_pkg::job_t head_job
);
  import z85_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  // status and head
  always_comb begin
    full       = (cnt_r == 2'd2);
    head_valid = (cnt_r != 2'd0);
    head_job   = mem_r[rd_ptr_r];
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("queue underflow");

  a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill");

endmodule

// ===== design/z85_back.sv =====
// back end: base-85 digit extraction and result word emission
module z85_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  z85_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_data_out,
  output logic          out_group_last,
  output logic          out_message_end,
  output logic          out_length_error
);
  import z85_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_DIV, C_HOLD} conv_state_t;

  conv_state_t state_r;
  logic [31:0] val_r;
  logic [31:0] prev_r;
  logic [2:0]  step_r;
  logic        last_r;
  logic [6:0]  dig_r [5];

  logic [7:0]  ebuf_r [5];
  logic [2:0]  ecnt_r;
  logic        elast_r;
  logic        elerr_r;

  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] val_x85;
  logic [31:0] rem_full;
  logic        take;
  logic        emit_free;
  logic        head_direct;
  logic        start_div;
  logic        direct_load;
  logic        hold_load;

  // one division by 85 per cycle, remainder from the previous quotient
  always_comb begin
    prod     = {32'd0, val_r} * {32'd0, DIV85_MAGIC};
    quo      = {6'd0, prod[63:DIV85_SHIFT]};
    val_x85  = (val_r << 6) + (val_r << 4) + (val_r << 2) + val_r;
    rem_full = prev_r - val_x85;
  end

  // hand-off control
  always_comb begin
    take        = (ecnt_r != 3'd0) && !out_stall;
    emit_free   = (ecnt_r == 3'd0) || ((ecnt_r == 3'd1) && take);
    head_direct = !head_job.enc || head_job.lerr;
    hold_load   = (state_r == C_HOLD) && emit_free;
    start_div   = head_valid && !head_direct &&
                  ((state_r == C_IDLE) || hold_load);
    direct_load = (state_r == C_IDLE) && head_valid && head_direct && emit_free;
    pop         = start_div || direct_load;
  end

  // result word outputs
  always_comb begin
    out_valid        = (ecnt_r != 3'd0);
    out_data_out     = ebuf_r[0];
    out_group_last   = (ecnt_r == 3'd1);
    out_message_end  = (ecnt_r == 3'd1) && elast_r;
    out_length_error = elerr_r;
  end

  // digit sequencer and output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      step_r  <= 3'd0;
      ecnt_r  <= 3'd0;
      elast_r <= 1'b0;
      elerr_r <= 1'b0;
    end else begin
      case (state_r)
        C_IDLE: begin
          if (start_div) begin
            val_r   <= head_job.val;
            last_r  <= head_job.last;
            step_r  <= 3'd0;
            state_r <= C_DIV;
          end
        end
        C_DIV: begin
          prev_r <= val_r;
          val_r  <= quo;
          // least significant digit lands in the last slot
          if (step_r != 3'd0) begin
            dig_r[ENC_DIGITS - step_r] <= rem_full[6:0];
          end
          if (step_r == ENC_DIGITS) begin
            state_r <= C_HOLD;
          end
          step_r <= step_r + 3'd1;
        end
        C_HOLD: begin
          if (start_div) begin
            val_r   <= head_job.val;
            last_r  <= head_job.last;
            step_r  <= 3'd0;
            state_r <= C_DIV;
          end else if (hold_load) begin
            state_r <= C_IDLE;
          end
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase

      // output buffer: load a group or shift out one word
      if (direct_load) begin
        if (head_job.lerr) begin
          ebuf_r[0] <= 8'd0;
          ecnt_r    <= 3'd1;
        end else begin
          ebuf_r[0] <= head_job.val[31:24];
          ebuf_r[1] <= head_job.val[23:16];
          ebuf_r[2] <= head_job.val[15:8];
          ebuf_r[3] <= head_job.val[7:0];
          ecnt_r    <= 3'd4;
        end
        ebuf_r[4] <= 8'd0;
        elast_r   <= head_job.last;
        elerr_r   <= head_job.lerr;
      end else if (hold_load) begin
        for (int i = 0; i < 5; i++) begin
          ebuf_r[i] <= z85_char(dig_r[i]);
        end
        ecnt_r  <= ENC_DIGITS;
        elast_r <= last_r;
        elerr_r <= 1'b0;
      end else if (take) begin
        for (int i = 0; i < 4; i++) begin
          ebuf_r[i] <= ebuf_r[i+1];
        end
        ecnt_r <= ecnt_r - 3'd1;
      end
    end
  end

  a_lerr_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length_error |-> out_group_last && out_message_end)
    else $error("length error word not alone");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == C_DIV |-> step_r <= ENC_DIGITS) else $error("digit step overrun");

  a_ecnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ecnt_r <= ENC_DIGITS) else $error("output buffer count out of range");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(direct_load && hold_load)) else $error("two loads of the output buffer");

endmodule

// ===== test/z85_codec_test.sv =====
// self-checking testbench for the z85 codec: word predictor class, stimulus tasks and checks

localparam logic [85*8-1:0] Z85_SYMBOLS =
  "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

typedef struct packed {
  logic [7:0] data;
  logic       group_last;
  logic       message_end;
  logic       length_error;
} z85_word_t;

// predicts the output words of the codec and checks them in order
class z85_scoreboard;
  bit           decoding;
  bit [31:0]    partial;
  bit [2:0]     gathered;
  byte unsigned symbol_of[85];
  byte unsigned digit_of[256];
  z85_word_t    due_words[$];
  int           errors;
  int           words_in;
  int           words_out;
  int           length_errors;

  function new();
    for (int c = 0; c < 256; c++) digit_of[c] = 8'd0;
    // digit lookup built by inverting the alphabet, unused codes stay at 0
    for (int d = 0; d < 85; d++) begin
      symbol_of[d] = Z85_SYMBOLS[8*(84-d) +: 8];
      digit_of[symbol_of[d]] = 8'(d);
    end
    decoding = 1'b0;
    partial = '0;
    gathered = '0;
    errors = 0;
    words_in = 0;
    words_out = 0;
    length_errors = 0;
  endfunction

  // a mode write drops any partial group
  function void set_mode(bit m);
    decoding = m;
    partial = '0;
    gathered = '0;
  endfunction

  function void take_input(logic [7:0] ch, logic last);
    bit [31:0] div;
    z85_word_t w;
    words_in++;
    if (!decoding) begin
      partial = (partial << 8) | ch;
    end else begin
      partial = partial * 32'd85 + digit_of[ch];
    end
    gathered = gathered + 3'd1;
    if (gathered == (decoding ? 3'd5 : 3'd4)) begin
      if (!decoding) begin
        // five characters, most significant digit first
        div = 32'd52200625;
        for (int i = 0; i < 5; i++) begin
          w.data = symbol_of[(partial / div) % 32'd85];
          w.group_last = (i == 4);
          w.message_end = last && (i == 4);
          w.length_error = 1'b0;
          due_words.push_back(w);
          div = div / 32'd85;
        end
      end else begin
        // four bytes, big-endian
        for (int i = 0; i < 4; i++) begin
          w.data = partial[31-8*i -: 8];
          w.group_last = (i == 3);
          w.message_end = last && (i == 3);
          w.length_error = 1'b0;
          due_words.push_back(w);
        end
      end
      partial = '0;
      gathered = '0;
    end else if (last) begin
      // message closed mid-group
      w.data = 8'h00;
      w.group_last = 1'b1;
      w.message_end = 1'b1;
      w.length_error = 1'b1;
      due_words.push_back(w);
      length_errors++;
      partial = '0;
      gathered = '0;
    end
  endfunction

  function void check_output(z85_word_t got);
    z85_word_t want;
    words_out++;
    if (due_words.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected output word: data=%02h gl=%b me=%b le=%b",
                 got.data, got.group_last, got.message_end, got.length_error);
      end
    end else begin
      want = due_words.pop_front();
      if (got.data !== want.data || got.group_last !== want.group_last ||
          got.message_end !== want.message_end || got.length_error !== want.length_error) begin
        errors++;
        if (errors <= 10) begin
          $display("output word %0d: expected data=%02h gl=%b me=%b le=%b,",
                   words_out, want.data, want.group_last, want.message_end,
                   want.length_error);
          $display("  got data=%02h gl=%b me=%b le=%b",
                   got.data, got.group_last, got.message_end, got.length_error);
        end
      end
    end
  endfunction
endclass

module z85_codec_test;

  localparam int ITEMS          = 470;
  localparam int HOLD_CYCLES    = 150;
  localparam int SETTLE         = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_mode;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_in;
  logic       in_last_in;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_data_out;
  logic       out_group_last;
  logic       out_message_end;
  logic       out_length_error;

  z85_scoreboard sb;
  bit quiet;
  bit calm;
  bit hold_off_req;
  int words_sent;
  int mode_writes;
  int hold_offs;
  int idle_cycles;

  z85_codec u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_mode         (cfg_mode),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_in       (in_data_in),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_out     (out_data_out),
    .out_group_last   (out_group_last),
    .out_message_end  (out_message_end),
    .out_length_error (out_length_error)
  );

  always #10 clk = ~clk;

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : rx_side
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        left = HOLD_CYCLES;
        hold_offs++;
      end else if (left == 0 && !quiet && !calm && $urandom_range(0, 9) == 0) begin
        left = $urandom_range(1, 11);
      end
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // check every accepted output word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_output({out_data_out, out_group_last, out_message_end, out_length_error});
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d words outstanding",
               idle_cycles, sb.due_words.size());
      $display("z85_codec_test: done, errors");
      $finish;
    end
  end

  task automatic write_mode(bit m);
    cfg_valid <= 1'b1;
    cfg_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_mode(m);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  // offer one word, sometimes with a random gap in front of it
  task automatic send_word(logic [7:0] d, logic l);
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_in <= d;
    in_last_in <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_input(d, l);
    words_sent++;
  endtask

  // mostly alphabet characters when decoding, any byte otherwise
  function automatic logic [7:0] random_char();
    if (sb.decoding && $urandom_range(0, 7) != 0) begin
      return sb.symbol_of[$urandom_range(0, 84)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_message(int n, bit close, bit noisy);
    logic l;
    for (int i = 0; i < n; i++) begin
      l = (close && i == n - 1) || (noisy && $urandom_range(0, 5) == 0);
      send_word(random_char(), l);
    end
  endtask

  // stop offering and let every expected word come out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int group;
    int kind;
    int n_msgs;
    int phase;
    int m;
    bit quiet_was;
    sb = new();
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_mode = 1'b0;
    in_valid = 1'b0;
    in_data_in = 8'h00;
    in_last_in = 1'b0;
    out_stall = 1'b0;
    quiet = 1'b0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    words_sent = 0;
    mode_writes = 0;
    hold_offs = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // encode: all-zero group, all-ones group closing the message
    write_mode(1'b0);
    send_word(8'h00, 1'b0); send_word(8'h00, 1'b0); send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0); send_word(8'hFF, 1'b0); send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b1);
    // encode message cut short
    send_word(8'h12, 1'b0); send_word(8'h80, 1'b0); send_word(8'h7F, 1'b1);
    // partial group dropped by the mode write
    send_word(8'hA5, 1'b0); send_word(8'h5A, 1'b0);
    drain();
    write_mode(1'b1);
    // decode: codes outside the alphabet count as zero
    send_word(8'h00, 1'b0); send_word(8'hFF, 1'b0); send_word(8'h80, 1'b0);
    send_word(8'h7F, 1'b0); send_word(8'h20, 1'b1);
    // largest digits, value wraps past 32 bits
    send_word(8'h23, 1'b0); send_word(8'h23, 1'b0); send_word(8'h23, 1'b0);
    send_word(8'h23, 1'b0); send_word(8'h23, 1'b1);
    // decode message cut short
    send_word(8'h30, 1'b0); send_word(8'h23, 1'b1);

    // random phases, each under a fresh mode write
    phase = 0;
    while (words_sent < ITEMS) begin
      drain();
      m = (phase % 3 == 2) ? $urandom_range(0, 1) : phase % 2;
      write_mode(m[0]);
      group = m ? 5 : 4;
      quiet = ($urandom_range(0, 3) == 0);
      n_msgs = $urandom_range(3, 7);
      for (int k = 0; k < n_msgs; k++) begin
        calm = (words_sent >= ITEMS - 60);
        kind = $urandom_range(0, 9);
        if (phase == 2 && k == 0) begin
          // long output hold-off while input keeps coming, fills the block
          quiet_was = quiet;
          quiet = 1'b1;
          hold_off_req = 1'b1;
          send_message(group * 8, 1'b1, 1'b0);
          quiet = quiet_was;
        end else if (kind < 7) begin
          send_message(group * $urandom_range(1, 4), 1'b1, 1'b0);
        end else if (kind < 9) begin
          send_message($urandom_range(1, 3 * group), 1'b1, 1'b0);
        end else begin
          send_message($urandom_range(1, 3 * group), 1'($urandom_range(0, 1)), 1'b1);
        end
        if (phase == 3 && k == 1) begin
          // sender waits for the output side to empty
          in_valid <= 1'b0;
          while (sb.due_words.size() != 0) @(posedge clk);
        end
      end
      // sometimes leave a partial group for the next mode write to drop
      if ($urandom_range(0, 3) == 0) begin
        send_message($urandom_range(1, group - 1), 1'b0, 1'b0);
      end
      phase++;
    end

    calm = 1'b1;
    drain();
    repeat (30) @(posedge clk);

    $display("z85 run: %0d words in, %0d words out, %0d length errors, %0d mode writes",
             sb.words_in, sb.words_out, sb.length_errors, mode_writes);
    $display("z85 run: encode and decode phases, %0d long hold-off(s), %0d mismatches",
             hold_offs, sb.errors);
    if (sb.errors == 0 && sb.due_words.size() == 0) begin
      $display("z85_codec_test: done, clean");
    end else begin
      $display("z85_codec_test: done, errors");
    end
    $finish;
  end

endmodule
